// ===== hdl/sscfw_pkg.sv =====
`default_nettype none

package sscfw_pkg;

    localparam int NUM_CHIPS_DEF = 3;
    localparam int FRAME_W       = 48;
    localparam int WORD_W        = 16;
    localparam int NUM_SLOTS     = FRAME_W / WORD_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int INIT_STEPS    = 5;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REFRESH_INIT = 2'd0,
        CFG_INTENSITY    = 2'd1,
        CFG_SCAN_LIMIT   = 2'd2,
        CFG_DECODE_MODE  = 2'd3
    } cfg_idx_t;

    // chip register addresses used by the init sequence
    localparam logic [7:0] ADDR_DECODE_MODE  = 8'h09;
    localparam logic [7:0] ADDR_INTENSITY    = 8'h0A;
    localparam logic [7:0] ADDR_SCAN_LIMIT   = 8'h0B;
    localparam logic [7:0] ADDR_SHUTDOWN     = 8'h0C;
    localparam logic [7:0] ADDR_DISPLAY_TEST = 8'h0F;

    localparam logic [7:0] POINT_BIT = 8'h80;

    // init sequence steps
    localparam logic [2:0] STEP_TEST      = 3'd0;
    localparam logic [2:0] STEP_INTENSITY = 3'd1;
    localparam logic [2:0] STEP_SCAN      = 3'd2;
    localparam logic [2:0] STEP_DECODE    = 3'd3;
    localparam logic [2:0] STEP_LAST      = 3'(INIT_STEPS - 1);

    typedef struct packed {
        logic       refresh_init;
        logic [3:0] intensity;
        logic [2:0] scan_limit;
        logic [7:0] decode_mode;
    } cfg_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic            raw;
        logic [1:0]      chip;
        logic            do_init;
        logic            do_digits;
        logic            wide;
        logic [3:0]      first;
        logic [3:0][7:0] code;
        logic [3:0]      reg_addr;
        logic [7:0]      reg_data;
    } task_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [3:0]  q;
        logic [15:0] r;
    } div_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_INIT,
        BK_DIGIT,
        BK_RAW
    } bk_state_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] c;
        unique case (d)
            4'd0:    c = 8'h7e;
            4'd1:    c = 8'h30;
            4'd2:    c = 8'h6d;
            4'd3:    c = 8'h79;
            4'd4:    c = 8'h33;
            4'd5:    c = 8'h5b;
            4'd6:    c = 8'h5f;
            4'd7:    c = 8'h70;
            4'd8:    c = 8'h7f;
            4'd9:    c = 8'h7b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // quotient (at most 9) and remainder by a constant, parallel compares
    function automatic div_t div_small(input logic [15:0] v, input logic [15:0] m);
        div_t        res;
        logic [19:0] t;
        res.q = '0;
        res.r = v;
        for (int k = 1; k <= 9; k++) begin
            t = 20'(k) * {4'b0000, m};
            if ({4'b0000, v} >= t) begin
                res.q = 4'(k);
                res.r = v - t[15:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/seven_segment_chain_frame_writer_core.sv =====
// Frame writer for a chain of seven-segment LED driver chips.
// Input channel (push/full): one transaction per edge with push high and full low.
//   cmd 0 shows value on digits of one chip, cmd 1 writes reg_data to reg_addr of chip.
// Result channel (empty/pop): each result is one 48-bit chain frame plus last,
//   which marks the final frame of an input transaction.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only while idle.
// Pipeline: an accepted input passes four digit-extraction stages, the task queue, the frame
//   sequencer and the output queue before its first frame shows on the result ports.
// Throughput: inputs are taken every cycle until the task queue fills; the sequencer
//   sends one frame per cycle while the output queue has room: 5*NUM_CHIPS+4 frames for a
//   four-digit transaction with init refresh (19 for three chips), one for a raw write.
// Reset clears all queues and restores the register defaults; the result
//   channel shows empty and the input channel is open at the first edge after reset.
// When the receiver stalls, the output queue fills, the sequencer holds, the task
//   queue fills and full rises; no frame is lost or repeated.
`default_nettype none

module seven_segment_chain_frame_writer_core
    import sscfw_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               cmd,
    input  wire logic [1:0]         chip,
    input  wire logic               wide,
    input  wire logic [1:0]         group,
    input  wire logic [15:0]        value,
    input  wire logic [2:0]         point,
    input  wire logic [3:0]         reg_addr,
    input  wire logic [7:0]         reg_data,
    output logic                    empty,
    input  wire logic               pop,
    output logic [FRAME_W-1:0]      frame,
    output logic                    last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_wr, q_rd, q_full, q_empty;
    task_t q_wdata, q_rdata;
    logic  o_wr, o_full;
    res_t  o_wdata, o_rdata;

    // configuration registers: accept every transaction
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REFRESH_INIT: cfg_next.refresh_init = cfg_data[0];
                CFG_INTENSITY:    cfg_next.intensity    = cfg_data[3:0];
                CFG_SCAN_LIMIT:   cfg_next.scan_limit   = cfg_data[2:0];
                CFG_DECODE_MODE:  cfg_next.decode_mode  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refresh_init <= 1'b1;
            cfg_reg.intensity    <= 4'd2;
            cfg_reg.scan_limit   <= 3'd7;
            cfg_reg.decode_mode  <= 8'h00;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: split the number into digits, classify, drop items with no frames
    sscfw_front #(
        .NUM_CHIPS (NUM_CHIPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .chip     (chip),
        .wide     (wide),
        .grp      (group),
        .value    (value),
        .point    (point),
        .reg_addr (reg_addr),
        .reg_data (reg_data),
        .cfg      (cfg_reg),
        .q_wr     (q_wr),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    // task queue: decouple the front stages from the frame sequencer
    sscfw_fifo #(
        .WIDTH ($bits(task_t))
    ) u_task_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // back: init, digit or raw words, one frame per cycle while the output queue has room
    sscfw_back #(
        .NUM_CHIPS (NUM_CHIPS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .o_full  (o_full),
        .o_wr    (o_wr),
        .o_data  (o_wdata)
    );

    // output queue: hold finished frames while the receiver stalls
    sscfw_fifo #(
        .WIDTH ($bits(res_t))
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_wr),
        .wr_data (o_wdata),
        .full    (o_full),
        .rd_en   (pop && !empty),
        .rd_data (o_rdata),
        .empty   (empty)
    );

    assign frame = o_rdata.frame;
    assign last  = o_rdata.last;

endmodule

`default_nettype wire

// ===== hdl/sscfw_fifo.sv =====
`default_nettype none

module sscfw_fifo
    import sscfw_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sscfw_front.sv =====
`default_nettype none

module sscfw_front
    import sscfw_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        cmd,
    input  wire logic [1:0]  chip,
    input  wire logic        wide,
    input  wire logic [1:0]  grp,
    input  wire logic [15:0] value,
    input  wire logic [2:0]  point,
    input  wire logic [3:0]  reg_addr,
    input  wire logic [7:0]  reg_data,
    input  wire cfg_t        cfg,
    output logic             q_wr,
    output task_t            q_data,
    input  wire logic        q_full
);

    localparam logic [2:0] CHIP_CNT = 3'(NUM_CHIPS);

    typedef struct packed {
        logic        cmd;
        logic [1:0]  chip;
        logic        wide;
        logic [1:0]  grp;
        logic [2:0]  point;
        logic [3:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [13:0] rem;
        logic [3:0]  d3;
        logic [3:0]  d2;
        logic [3:0]  d1;
    } fr_stage_t;

    fr_stage_t  stg_reg  [4];
    fr_stage_t  stg_next [4];
    logic [3:0] vld_reg, vld_next;
    div_t       d_wide, d_narrow, d_thou, d_hund, d_tens;
    fr_stage_t  s;
    logic       chip_ok;
    logic       keep;
    logic       en;
    logic [3:0] d0;

    // digit extraction: one decimal place per stage
    always_comb
    begin
        d_wide   = div_small(value, 16'd10000);
        d_narrow = div_small({8'h00, value[7:0]}, 16'd100);

        stg_next[0].cmd      = cmd;
        stg_next[0].chip     = chip;
        stg_next[0].wide     = wide;
        stg_next[0].grp      = grp;
        stg_next[0].point    = point;
        stg_next[0].reg_addr = reg_addr;
        stg_next[0].reg_data = reg_data;
        stg_next[0].rem      = wide ? d_wide.r[13:0] : d_narrow.r[13:0];
        stg_next[0].d3       = '0;
        stg_next[0].d2       = '0;
        stg_next[0].d1       = '0;

        d_thou          = div_small({2'b00, stg_reg[0].rem}, 16'd1000);
        stg_next[1]     = stg_reg[0];
        stg_next[1].d3  = d_thou.q;
        stg_next[1].rem = d_thou.r[13:0];

        d_hund          = div_small({2'b00, stg_reg[1].rem}, 16'd100);
        stg_next[2]     = stg_reg[1];
        stg_next[2].d2  = d_hund.q;
        stg_next[2].rem = d_hund.r[13:0];

        d_tens          = div_small({2'b00, stg_reg[2].rem}, 16'd10);
        stg_next[3]     = stg_reg[2];
        stg_next[3].d1  = d_tens.q;
        stg_next[3].rem = d_tens.r[13:0];
    end

    // classify the finished item and build its task
    always_comb
    begin
        s       = stg_reg[3];
        d0      = s.rem[3:0];
        chip_ok = ({1'b0, s.chip} < CHIP_CNT);

        q_data.raw       = s.cmd;
        q_data.chip      = s.chip;
        q_data.do_init   = !s.cmd && cfg.refresh_init;
        q_data.do_digits = !s.cmd && chip_ok && (!s.wide || !s.grp[1]);
        q_data.wide      = s.wide;
        q_data.first     = s.wide ? {s.grp, 2'b00} + 4'd1 : {1'b0, s.grp, 1'b0} + 4'd1;
        q_data.reg_addr  = s.reg_addr;
        q_data.reg_data  = s.reg_data;
        if (s.wide)
        begin
            q_data.code[0] = seg_code(s.d3) | ((s.point == 3'd4) ? POINT_BIT : 8'h00);
            q_data.code[1] = seg_code(s.d2) | ((s.point == 3'd3) ? POINT_BIT : 8'h00);
            q_data.code[2] = seg_code(s.d1) | ((s.point == 3'd2) ? POINT_BIT : 8'h00);
            q_data.code[3] = seg_code(d0)   | ((s.point == 3'd1) ? POINT_BIT : 8'h00);
        end
        else
        begin
            q_data.code[0] = seg_code(s.d1) | ((s.point == 3'd2) ? POINT_BIT : 8'h00);
            q_data.code[1] = seg_code(d0)   | ((s.point == 3'd1) ? POINT_BIT : 8'h00);
            q_data.code[2] = 8'h00;
            q_data.code[3] = 8'h00;
        end

        // drop items that cause no frame
        keep = s.cmd ? chip_ok : (q_data.do_init || q_data.do_digits);
        en   = !(vld_reg[3] && keep && q_full);
        full = !en;
        q_wr = vld_reg[3] && keep && !q_full;
        vld_next = {vld_reg[2:0], push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg <= stg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sscfw_back.sv =====
`default_nettype none

module sscfw_back
    import sscfw_pkg::*;
#(
    parameter int NUM_CHIPS = NUM_CHIPS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_empty,
    input  wire task_t q_data,
    output logic       q_rd,
    input  wire logic  o_full,
    output logic       o_wr,
    output res_t       o_data
);

    localparam logic [1:0] CHIP_LAST = 2'(NUM_CHIPS - 1);

    bk_state_t  state_reg, state_next;
    task_t      cur_reg;
    logic [2:0] step_reg, step_next;
    logic [1:0] ichip_reg, ichip_next;
    logic [1:0] didx_reg, didx_next;

    logic [7:0]  word_addr;
    logic [7:0]  word_data;
    logic [1:0]  word_chip;
    logic        is_last;
    logic        init_end;
    logic        emit;
    logic        load;
    logic [15:0] word;

    function automatic bk_state_t start_state(input task_t t);
        bk_state_t st;
        if (t.raw)
            st = BK_RAW;
        else if (t.do_init)
            st = BK_INIT;
        else
            st = BK_DIGIT;
        return st;
    endfunction

    function automatic logic [7:0] init_addr(input logic [2:0] step);
        logic [7:0] a;
        case (step)
            STEP_TEST:      a = ADDR_DISPLAY_TEST;
            STEP_INTENSITY: a = ADDR_INTENSITY;
            STEP_SCAN:      a = ADDR_SCAN_LIMIT;
            STEP_DECODE:    a = ADDR_DECODE_MODE;
            default:        a = ADDR_SHUTDOWN;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] init_data(input logic [2:0] step, input cfg_t c);
        logic [7:0] d;
        case (step)
            STEP_TEST:      d = 8'h00;
            STEP_INTENSITY: d = {4'h0, c.intensity};
            STEP_SCAN:      d = {5'h00, c.scan_limit};
            STEP_DECODE:    d = c.decode_mode;
            default:        d = 8'h01;
        endcase
        return d;
    endfunction

    // frame word and handshakes
    always_comb
    begin
        word_addr = '0;
        word_data = '0;
        word_chip = cur_reg.chip;
        is_last   = 1'b0;
        init_end  = (step_reg == STEP_LAST) && (ichip_reg == CHIP_LAST);
        unique case (state_reg)
            BK_IDLE:
            begin
                is_last = 1'b0;
            end
            BK_INIT:
            begin
                word_addr = init_addr(step_reg);
                word_data = init_data(step_reg, cfg);
                word_chip = ichip_reg;
                is_last   = init_end && !cur_reg.do_digits;
            end
            BK_DIGIT:
            begin
                word_addr = {4'h0, cur_reg.first + {2'b00, didx_reg}};
                word_data = cur_reg.code[didx_reg];
                is_last   = (didx_reg == (cur_reg.wide ? 2'd3 : 2'd1));
            end
            BK_RAW:
            begin
                word_addr = {4'h0, cur_reg.reg_addr};
                word_data = cur_reg.reg_data;
                is_last   = 1'b1;
            end
        endcase

        word = {word_addr, word_data};
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            o_data.frame[k*WORD_W +: WORD_W] = (word_chip == 2'(k)) ? word : '0;
        end
        o_data.last = is_last;

        emit = (state_reg != BK_IDLE) && !o_full;
        load = !q_empty && ((state_reg == BK_IDLE) || (emit && is_last));
        o_wr = emit;
        q_rd = load;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = start_state(q_data);
        end
        else if (emit)
        begin
            if (is_last)
            begin
                state_next = BK_IDLE;
            end
            else if (state_reg == BK_INIT && init_end)
            begin
                state_next = BK_DIGIT;
            end
        end
    end

    // step counters
    always_comb
    begin
        step_next  = step_reg;
        ichip_next = ichip_reg;
        didx_next  = didx_reg;
        if (load)
        begin
            step_next  = '0;
            ichip_next = '0;
            didx_next  = '0;
        end
        else if (emit && state_reg == BK_INIT)
        begin
            if (ichip_reg == CHIP_LAST)
            begin
                ichip_next = '0;
                step_next  = step_reg + 3'd1;
            end
            else
            begin
                ichip_next = ichip_reg + 2'd1;
            end
        end
        else if (emit && state_reg == BK_DIGIT)
        begin
            didx_next = didx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
            ichip_reg <= '0;
            didx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ichip_reg <= ichip_next;
            didx_reg  <= didx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sscfw_checker.sv =====
`default_nettype none

module sscfw_checker
    import sscfw_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic [FRAME_W-1:0] frame,
    input wire logic               last
);

    // leave reset with nothing queued and the input open
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

    // a frame addresses at most one chip
    a_one_chip: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot0({|frame[47:32], |frame[31:16], |frame[15:0]}))
        else $error("frame addresses more than one chip");

    // chip register addresses stay below 0x10
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame[47:44] == 4'h0 && frame[31:28] == 4'h0 && frame[15:12] == 4'h0))
        else $error("register address out of range");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame) && $stable(last)))
        else $error("waiting result changed");

endmodule

bind seven_segment_chain_frame_writer_core sscfw_checker u_sscfw_checker (.*);

`default_nettype wire

// ===== tb/chain_frame_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

module chain_frame_checker
    import sscfw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic               cmd,
    input  wire logic [1:0]         chip,
    input  wire logic               wide,
    input  wire logic [1:0]         group,
    input  wire logic [15:0]        value,
    input  wire logic [2:0]         point,
    input  wire logic [3:0]         reg_addr,
    input  wire logic [7:0]         reg_data,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire logic               last,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    output int                      fail_count,
    output int                      frames_owed
);

    localparam int CHAIN_LEN  = NUM_CHIPS_DEF;
    localparam logic [7:0] DIGIT_SEGS [0:9] = '{
        8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
    };

    cfg_t chain_regs;
    res_t frames_due [$];
    int   mismatches = 0;
    int   owed       = 0;

    assign fail_count  = mismatches;
    assign frames_owed = owed;

    function automatic logic [FRAME_W-1:0] chain_word(input logic [1:0] pos,
                                                      input logic [7:0] addr,
                                                      input logic [7:0] data);
        logic [63:0] w;
        w = {48'd0, addr, data} << (16 * pos);
        return w[FRAME_W-1:0];
    endfunction

    // expand one input transaction into the frames it must produce
    task automatic predict_frames(input logic c, input logic [1:0] pos, input logic w,
                                  input logic [1:0] grp, input logic [15:0] v,
                                  input logic [2:0] pt, input logic [3:0] ra,
                                  input logic [7:0] rd);
        logic [FRAME_W-1:0] seq [$];
        logic [7:0]         init_addr [INIT_STEPS];
        logic [7:0]         init_data [INIT_STEPS];
        logic [3:0]         digs [4];
        logic [7:0]         seg;
        res_t               r;
        int                 ndig;
        int                 num;
        int                 first;
        int                 s;
        int                 p;
        int                 j;
        init_addr = '{ADDR_DISPLAY_TEST, ADDR_INTENSITY, ADDR_SCAN_LIMIT,
                      ADDR_DECODE_MODE, ADDR_SHUTDOWN};
        init_data = '{8'd0, {4'd0, chain_regs.intensity}, {5'd0, chain_regs.scan_limit},
                      chain_regs.decode_mode, 8'd1};
        if (c) begin
            if (pos < CHAIN_LEN)
                seq.push_back(chain_word(pos, {4'd0, ra}, rd));
        end
        else begin
            if (chain_regs.refresh_init)
                for (s = 0; s < INIT_STEPS; s++)
                    for (p = 0; p < CHAIN_LEN; p++)
                        seq.push_back(chain_word(2'(p), init_addr[s], init_data[s]));
            if (pos < CHAIN_LEN && (!w || grp < 2)) begin
                ndig  = w ? 4 : 2;
                num   = w ? int'(v) % 10000 : int'(v[7:0]) % 100;
                first = int'(grp) * ndig + 1;
                for (j = 0; j < ndig; j++) begin
                    digs[j] = 4'(num % 10);
                    num     = num / 10;
                end
                // most significant digit first, point counted from the right
                for (j = ndig - 1; j >= 0; j--) begin
                    seg = DIGIT_SEGS[digs[j]];
                    if (int'(pt) == j + 1)
                        seg = seg | POINT_BIT;
                    seq.push_back(chain_word(pos, 8'(first + ndig - 1 - j), seg));
                end
            end
        end
        for (j = 0; j < seq.size(); j++) begin
            r.frame = seq[j];
            r.last  = (j == seq.size() - 1);
            frames_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        res_t want;
        if (!rst_n) begin
            chain_regs.refresh_init = 1'b1;
            chain_regs.intensity    = 4'd2;
            chain_regs.scan_limit   = 3'd7;
            chain_regs.decode_mode  = 8'd0;
            frames_due.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_REFRESH_INIT: chain_regs.refresh_init = cfg_data[0];
                    CFG_INTENSITY:    chain_regs.intensity    = cfg_data[3:0];
                    CFG_SCAN_LIMIT:   chain_regs.scan_limit   = cfg_data[2:0];
                    CFG_DECODE_MODE:  chain_regs.decode_mode  = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (frames_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: frame expected none actual %h last %b",
                             $time, frame, last);
                end
                else begin
                    want = frames_due.pop_front();
                    if (frame !== want.frame) begin
                        mismatches++;
                        $display("%0t: frame expected %h actual %h",
                                 $time, want.frame, frame);
                    end
                    if (last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, last);
                    end
                end
            end
            if (push && !full)
                predict_frames(cmd, chip, wide, group, value, point, reg_addr, reg_data);
        end
        owed = frames_due.size();
    end

endmodule

`default_nettype wire

// ===== tb/seven_segment_chain_frame_writer_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module seven_segment_chain_frame_writer_core_tb;
    import sscfw_pkg::*;

    // generous ceiling on the length of the run
    localparam int RUN_LIMIT   = 200000;
    // settle time after the last owed frame; covers transactions that emit nothing
    localparam int SETTLE_TAIL = 30;
    // receiver hold-off long enough to back the block up into full
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 17;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  chip;
        logic        wide;
        logic [1:0]  group;
        logic [15:0] value;
        logic [2:0]  point;
        logic [3:0]  reg_addr;
        logic [7:0]  reg_data;
    } panel_req_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               cmd       = 1'b0;
    logic [1:0]         chip      = '0;
    logic               wide      = 1'b0;
    logic [1:0]         group     = '0;
    logic [15:0]        value     = '0;
    logic [2:0]         point     = '0;
    logic [3:0]         reg_addr  = '0;
    logic [7:0]         reg_data  = '0;
    logic               pop       = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data  = '0;
    logic               full;
    logic               empty;
    logic [FRAME_W-1:0] frame;
    logic               last;
    logic               cfg_ready;

    int   fail_count;
    int   frames_owed;
    int   cycle_count = 0;
    // steady: both sides stop idling; hold_req: receiver goes quiet for a while
    bit   steady      = 1'b0;
    bit   hold_req    = 1'b0;

    seven_segment_chain_frame_writer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .chip      (chip),
        .wide      (wide),
        .group     (group),
        .value     (value),
        .point     (point),
        .reg_addr  (reg_addr),
        .reg_data  (reg_data),
        .empty     (empty),
        .pop       (pop),
        .frame     (frame),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chain_frame_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .chip        (chip),
        .wide        (wide),
        .group       (group),
        .value       (value),
        .point       (point),
        .reg_addr    (reg_addr),
        .reg_data    (reg_data),
        .empty       (empty),
        .pop         (pop),
        .frame       (frame),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .frames_owed (frames_owed)
    );

    always #5 clk = ~clk;

    // hold reset low from the start, then release it once
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // bail out if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: pop at random, pop every cycle while steady, and go quiet for a
    // long stretch when asked so the output and task queues back up.
    initial
    begin : result_side
        int k;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                pop <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic panel_req_t make_req(input logic c, input logic [1:0] ch,
                                            input logic w, input logic [1:0] g,
                                            input logic [15:0] v, input logic [2:0] pt,
                                            input logic [3:0] ra, input logic [7:0] rd);
        panel_req_t r;
        r.cmd      = c;
        r.chip     = ch;
        r.wide     = w;
        r.group    = g;
        r.value    = v;
        r.point    = pt;
        r.reg_addr = ra;
        r.reg_data = rd;
        return r;
    endfunction

    // Mostly well-formed display transactions, a share of raw writes, and some
    // noise: chip 3, invalid groups, points with no digit.
    function automatic panel_req_t random_req();
        panel_req_t  r;
        logic [63:0] rand_bits;
        int          kind;
        rand_bits = {$urandom, $urandom};
        r    = rand_bits[$bits(panel_req_t)-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            r.cmd   = 1'b0;
            r.chip  = 2'($urandom_range(0, 2));
            r.group = r.wide ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
            r.point = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : r.point;
            if ($urandom_range(0, 3) == 0)
                r.value = 16'($urandom_range(0, 120));
        end
        else if (kind < 85) begin
            r.cmd  = 1'b1;
            r.chip = 2'($urandom_range(0, 2));
        end
        return r;
    endfunction

    // Idle the input side for a cycle now and then; never while steady.
    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one transaction and hold it until the edge that takes it.
    task automatic offer(input panel_req_t r);
        push     <= 1'b1;
        cmd      <= r.cmd;
        chip     <= r.chip;
        wide     <= r.wide;
        group    <= r.group;
        value    <= r.value;
        point    <= r.point;
        reg_addr <= r.reg_addr;
        reg_data <= r.reg_data;
        do @(negedge clk); while (full);
        @(posedge clk);
    endtask

    // Drop push, wait for every owed frame, then let in-flight work finish.
    task automatic drain_block();
        push <= 1'b0;
        do @(negedge clk); while (frames_owed != 0);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // Write all four registers back to back; only called with the block drained.
    task automatic load_regs(input logic [7:0] refresh, input logic [7:0] bright,
                             input logic [7:0] scan, input logic [7:0] decode);
        write_reg(CFG_REFRESH_INIT, refresh);
        write_reg(CFG_INTENSITY, bright);
        write_reg(CFG_SCAN_LIMIT, scan);
        write_reg(CFG_DECODE_MODE, decode);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(input int count, input int hold_at);
        int n;
        for (n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_req = 1'b1;
            sender_gap();
            offer(random_req());
        end
    endtask

    initial
    begin : stimulus
        panel_req_t directed [$];
        int         n;
        @(posedge rst_n);
        @(posedge clk);

        // Directed transactions under the reset register values: digit
        // extremes, both group widths, invalid groups, chip out of range,
        // points with no digit, and raw writes including the dropped one.
        directed.push_back(make_req(1'b0, 2'd0, 1'b1, 2'd0, 16'd0,     3'd0, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd2, 1'b1, 2'd1, 16'hffff,  3'd4, 4'hf,  8'hff));
        directed.push_back(make_req(1'b0, 2'd1, 1'b1, 2'd0, 16'd9999,  3'd1, 4'd3,  8'h5a));
        directed.push_back(make_req(1'b0, 2'd0, 1'b1, 2'd1, 16'd12345, 3'd3, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd2, 1'b1, 2'd0, 16'd6789,  3'd2, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd0, 1'b0, 2'd0, 16'd255,   3'd2, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd2, 1'b0, 2'd3, 16'd99,    3'd1, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd1, 1'b0, 2'd2, 16'hff64,  3'd3, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd1, 1'b0, 2'd1, 16'd7,     3'd4, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd0, 1'b1, 2'd2, 16'd1234,  3'd1, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd1, 1'b1, 2'd3, 16'd4321,  3'd2, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd3, 1'b1, 2'd0, 16'd5555,  3'd1, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd1, 1'b1, 2'd1, 16'd3141,  3'd5, 4'd0,  8'd0));
        directed.push_back(make_req(1'b0, 2'd2, 1'b1, 2'd0, 16'd2718,  3'd7, 4'd0,  8'd0));
        directed.push_back(make_req(1'b1, 2'd0, 1'b0, 2'd0, 16'd0,     3'd0, 4'd0,  8'd0));
        directed.push_back(make_req(1'b1, 2'd2, 1'b1, 2'd3, 16'hffff,  3'd7, 4'hf,  8'hff));
        directed.push_back(make_req(1'b1, 2'd1, 1'b0, 2'd1, 16'd0,     3'd0, 4'ha,  8'ha5));
        directed.push_back(make_req(1'b1, 2'd3, 1'b0, 2'd0, 16'd0,     3'd0, 4'h5,  8'h3c));
        for (n = 0; n < directed.size(); n++) begin
            sender_gap();
            offer(directed[n]);
        end
        drain_block();

        // Extremes one way; the receiver goes quiet partway through so full rises.
        load_regs(8'd1, 8'd15, 8'd0, 8'd255);
        random_burst(50, 12);
        drain_block();

        // No init refresh: display transactions shrink to their digit frames,
        // and some emit nothing at all.
        load_regs(8'd0, 8'd0, 8'd7, 8'd0);
        random_burst(50, -1);
        drain_block();

        // Random register bytes, upper bits included; run with no idling.
        load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        steady = 1'b1;
        random_burst(50, -1);
        drain_block();
        steady = 1'b0;

        load_regs(8'd1, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 7)), 8'($urandom));
        random_burst(42, 30);
        drain_block();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/sscfw_pkg.sv
hdl/sscfw_fifo.sv
hdl/sscfw_front.sv
hdl/sscfw_back.sv
hdl/seven_segment_chain_frame_writer_core.sv
hdl/sscfw_checker.sv
tb/chain_frame_checker.sv
tb/seven_segment_chain_frame_writer_core_tb.sv
